// File: rtl/core/kmmne_pkg.sv
package kmmne_pkg;

	localparam int COLUMNS = 4;
	localparam int ROWS = 4;

	localparam int RowsUsed = (ROWS < 4) ? ROWS : 4;
	localparam logic [3:0] RowMask = 4'((1 << RowsUsed) - 1);

	localparam logic [7:0] NoteOnStatus = 8'h90;
	localparam logic [7:0] NoteOffStatus = 8'h80;

	localparam logic [6:0] BaseNoteReset = 7'd36;
	localparam logic [6:0] OnVelocityReset = 7'd100;
	localparam logic [3:0] MidiChannelReset = 4'd0;

	localparam int ApbAddrW = 4;
	localparam int ApbDataW = 32;

	localparam int FifoDepth = 2;
	localparam int FifoIdxW = $clog2(FifoDepth);
	localparam int FifoCntW = $clog2(FifoDepth + 1);

	typedef enum logic [1:0] {
		RegBaseNote    = 2'd0,
		RegOnVelocity  = 2'd1,
		RegMidiChannel = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [6:0] base_note;
		logic [6:0] on_velocity;
		logic [3:0] midi_channel;
	} cfg_t;

	typedef struct packed {
		logic [1:0] column;
		logic [3:0] levels;
		logic [3:0] changed;
	} job_t;

endpackage

// File: rtl/core/kmmne_if.sv
interface kmmne_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] column;
	logic [3:0] row_levels;
	logic       link_ready;

	modport source(output valid, output column, output row_levels, output link_ready,
		input ready);
	modport sink(input valid, input column, input row_levels, input link_ready,
		output ready);
endinterface

interface kmmne_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] status_byte;
	logic [6:0] note_number;
	logic [6:0] velocity;
	logic       last;

	modport source(output valid, output status_byte, output note_number, output velocity,
		output last, input ready);
	modport sink(input valid, input status_byte, input note_number, input velocity,
		input last, output ready);
endinterface

// File: rtl/core/key_matrix_midi_note_events_unit.sv
// Turns column scans of a key matrix into MIDI Note On and Note Off events, one
// event per changed row in ascending row order, with last set on the final event
// of a scan. A scan transaction is accepted in any cycle in which the two-entry
// queue between the scan front end and the event back end has room, so scans can
// arrive back to back; the back end then emits one event per cycle while the
// MIDI sink is ready, so a scan with k changed rows (0 to 4) yields k events.
// Scans with no change or with the link not ready only update the stored row
// levels and produce no events, and a scan of a column outside the matrix is
// ignored entirely. Registers base_note (0x0), on_velocity (0x4) and midi_channel
// (0x8) sit on the APB port and should be written only while idle.
module key_matrix_midi_note_events_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	kmmne_in_if.sink                         scan,
	kmmne_out_if.source                      midi,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [kmmne_pkg::ApbAddrW-1:0]   paddr,
	input  logic [kmmne_pkg::ApbDataW-1:0]   pwdata,
	output logic [kmmne_pkg::ApbDataW-1:0]   prdata,
	output logic                             pready
);

	kmmne_pkg::cfg_t   cfg_q;
	kmmne_pkg::reg_idx_t reg_idx;
	logic              cfg_wr;
	logic              push;
	logic              pop;
	logic              queue_full;
	logic              queue_empty;
	kmmne_pkg::job_t   push_job;
	kmmne_pkg::job_t   head_job;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign reg_idx = kmmne_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_note <= kmmne_pkg::BaseNoteReset;
			cfg_q.on_velocity <= kmmne_pkg::OnVelocityReset;
			cfg_q.midi_channel <= kmmne_pkg::MidiChannelReset;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				kmmne_pkg::RegBaseNote: begin
					cfg_q.base_note <= pwdata[6:0];
				end
				kmmne_pkg::RegOnVelocity: begin
					cfg_q.on_velocity <= pwdata[6:0];
				end
				kmmne_pkg::RegMidiChannel: begin
					cfg_q.midi_channel <= pwdata[3:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			kmmne_pkg::RegBaseNote: begin
				prdata = {25'b0, cfg_q.base_note};
			end
			kmmne_pkg::RegOnVelocity: begin
				prdata = {25'b0, cfg_q.on_velocity};
			end
			kmmne_pkg::RegMidiChannel: begin
				prdata = {28'b0, cfg_q.midi_channel};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	kmmne_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.scan       (scan),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job)
	);

	kmmne_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.full     (queue_full),
		.empty    (queue_empty)
	);

	kmmne_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head_job    (head_job),
		.queue_empty (queue_empty),
		.pop         (pop),
		.midi        (midi)
	);

endmodule

// File: rtl/core/kmmne_fifo.sv
module kmmne_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  kmmne_pkg::job_t   push_job,
	input  logic              pop,
	output kmmne_pkg::job_t   head_job,
	output logic              full,
	output logic              empty
);

	kmmne_pkg::job_t mem_q [kmmne_pkg::FifoDepth];
	logic [kmmne_pkg::FifoIdxW-1:0] wr_ptr_q;
	logic [kmmne_pkg::FifoIdxW-1:0] rd_ptr_q;
	logic [kmmne_pkg::FifoCntW-1:0] count_q;

	assign full = (count_q == kmmne_pkg::FifoCntW'(kmmne_pkg::FifoDepth));
	assign empty = (count_q == '0);
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("transaction pushed into a full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= kmmne_pkg::FifoCntW'(kmmne_pkg::FifoDepth))
		else $error("queue count out of range");

endmodule

// File: rtl/core/kmmne_front.sv
module kmmne_front (
	input  logic             clk,
	input  logic             arst_n,
	kmmne_in_if.sink         scan,
	input  logic             queue_full,
	output logic             push,
	output kmmne_pkg::job_t  push_job
);

	logic [3:0] prev_q [kmmne_pkg::COLUMNS];
	logic [3:0] prev_rows;
	logic [3:0] levels;
	logic       accept;
	logic       col_ok;

	assign scan.ready = !queue_full;
	assign accept = scan.valid && scan.ready;
	assign col_ok = int'(scan.column) < kmmne_pkg::COLUMNS;
	assign levels = scan.row_levels & kmmne_pkg::RowMask;

	always_comb begin
		prev_rows = kmmne_pkg::RowMask;
		for (int c = 0; c < kmmne_pkg::COLUMNS; c++) begin
			if (int'(scan.column) == c) begin
				prev_rows = prev_q[c];
			end
		end
	end

	assign push_job.column = scan.column;
	assign push_job.levels = levels;
	assign push_job.changed = levels ^ prev_rows;
	assign push = accept && col_ok && scan.link_ready && (push_job.changed != 4'b0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < kmmne_pkg::COLUMNS; c++) begin
				prev_q[c] <= kmmne_pkg::RowMask;
			end
		end else if (accept) begin
			for (int c = 0; c < kmmne_pkg::COLUMNS; c++) begin
				if (int'(scan.column) == c) begin
					prev_q[c] <= levels;
				end
			end
		end
	end

endmodule

// File: rtl/core/kmmne_back.sv
module kmmne_back (
	input  logic             clk,
	input  logic             arst_n,
	input  kmmne_pkg::cfg_t  cfg,
	input  kmmne_pkg::job_t  head_job,
	input  logic             queue_empty,
	output logic             pop,
	kmmne_out_if.source      midi
);

	logic            busy_q;
	kmmne_pkg::job_t job_q;
	logic            out_valid_q;
	logic [7:0]      status_q;
	logic [6:0]      note_q;
	logic [6:0]      velocity_q;
	logic            last_q;

	kmmne_pkg::job_t cur;
	logic            cur_valid;
	logic            slot_free;
	logic            fire;
	logic [1:0]      row;
	logic [3:0]      rest;
	logic            press;
	logic [6:0]      note;

	assign cur = busy_q ? job_q : head_job;
	assign cur_valid = busy_q || !queue_empty;
	assign slot_free = !out_valid_q || midi.ready;
	assign fire = cur_valid && slot_free;
	assign pop = fire && !busy_q;

	always_comb begin
		row = 2'd0;
		for (int i = 3; i >= 0; i--) begin
			if (cur.changed[i]) begin
				row = 2'(i);
			end
		end
	end

	assign rest = cur.changed & ~(4'b1 << row);
	assign press = !cur.levels[row];
	assign note = cfg.base_note + 7'(cur.column) * 7'(kmmne_pkg::ROWS) + 7'(row);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				busy_q <= (rest != 4'b0);
				out_valid_q <= 1'b1;
			end else if (midi.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			job_q.column <= cur.column;
			job_q.levels <= cur.levels;
			job_q.changed <= rest;
			status_q <= (press ? kmmne_pkg::NoteOnStatus : kmmne_pkg::NoteOffStatus)
				| {4'b0, cfg.midi_channel};
			note_q <= note;
			velocity_q <= press ? cfg.on_velocity : 7'd0;
			last_q <= (rest == 4'b0);
		end
	end

	assign midi.valid = out_valid_q;
	assign midi.status_byte = status_q;
	assign midi.note_number = note_q;
	assign midi.velocity = velocity_q;
	assign midi.last = last_q;

	a_busy_has_rows: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (job_q.changed != 4'b0))
		else $error("job in progress with no rows left");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !queue_empty)
		else $error("pop from an empty queue");

endmodule

// File: sim/note_event_checker.sv
module note_event_checker
	import kmmne_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	kmmne_in_if                 scan,
	kmmne_out_if                midi,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [ApbAddrW-1:0] paddr,
	input  logic [ApbDataW-1:0] pwdata,
	output int                  fail_count,
	output int                  pending_events
);

	typedef struct packed {
		logic [7:0] status_byte;
		logic [6:0] note_number;
		logic [6:0] velocity;
		logic       last;
	} midi_event_t;

	midi_event_t expected_events[$];
	logic [3:0]  held_rows[COLUMNS];
	logic [6:0]  base_note;
	logic [6:0]  on_velocity;
	logic [3:0]  midi_channel;
	int          mismatch_count = 0;

	assign fail_count = mismatch_count;

	task automatic report_mismatch(input string msg);
		$display("[%0t] MIDI event mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic predict_note_events(input logic [1:0] column, input logic [3:0] row_levels,
		input logic link_ready);
		logic [3:0]  levels;
		logic [3:0]  changed;
		midi_event_t ev;
		if (int'(column) >= COLUMNS) begin
			return;
		end
		levels = row_levels & RowMask;
		changed = levels ^ held_rows[column];
		held_rows[column] = levels;
		if (!link_ready) begin
			return;
		end
		for (int r = 0; r < 4; r++) begin
			if (changed[r]) begin
				if (!levels[r]) begin
					ev.status_byte = NoteOnStatus | {4'h0, midi_channel};
					ev.velocity = on_velocity;
				end else begin
					ev.status_byte = NoteOffStatus | {4'h0, midi_channel};
					ev.velocity = 7'd0;
				end
				ev.note_number = 7'(int'(base_note) + int'(column) * ROWS + r);
				ev.last = ((changed >> (r + 1)) == 4'h0);
				expected_events.push_back(ev);
			end
		end
	endtask

	task automatic check_note_event();
		midi_event_t want;
		if (expected_events.size() == 0) begin
			report_mismatch($sformatf("unexpected event status 0x%0h note %0d velocity %0d",
				midi.status_byte, midi.note_number, midi.velocity));
			return;
		end
		want = expected_events.pop_front();
		if (midi.status_byte !== want.status_byte) begin
			report_mismatch($sformatf("status_byte expected 0x%0h, got 0x%0h",
				want.status_byte, midi.status_byte));
		end
		if (midi.note_number !== want.note_number) begin
			report_mismatch($sformatf("note_number expected %0d, got %0d",
				want.note_number, midi.note_number));
		end
		if (midi.velocity !== want.velocity) begin
			report_mismatch($sformatf("velocity expected %0d, got %0d",
				want.velocity, midi.velocity));
		end
		if (midi.last !== want.last) begin
			report_mismatch($sformatf("last expected %0b, got %0b", want.last, midi.last));
		end
	endtask

	task automatic write_register(input logic [ApbAddrW-1:0] addr, input logic [ApbDataW-1:0] data);
		case (reg_idx_t'(addr[ApbAddrW-1:2]))
			RegBaseNote: begin
				base_note = data[6:0];
			end
			RegOnVelocity: begin
				on_velocity = data[6:0];
			end
			RegMidiChannel: begin
				midi_channel = data[3:0];
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_events.delete();
			foreach (held_rows[c]) begin
				held_rows[c] = RowMask;
			end
			base_note = BaseNoteReset;
			on_velocity = OnVelocityReset;
			midi_channel = MidiChannelReset;
			pending_events <= 0;
		end else begin
			if (midi.valid && midi.ready) begin
				check_note_event();
			end
			if (scan.valid && scan.ready) begin
				predict_note_events(scan.column, scan.row_levels, scan.link_ready);
			end
			if (psel && penable && pwrite && pready) begin
				write_register(paddr, pwdata);
			end
			pending_events <= expected_events.size();
		end
	end

endmodule

// File: sim/tb_key_matrix_midi_note_events_unit.sv
module tb_key_matrix_midi_note_events_unit;
	import kmmne_pkg::*;

	localparam int WatchdogLimit = 3000;
	localparam int DrainCycles = 16;
	localparam int ItemsPerPhase = 41;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ApbAddrW-1:0] paddr;
	logic [ApbDataW-1:0] pwdata;
	logic [ApbDataW-1:0] prdata;
	logic                pready;
	int                  fail_count;
	int                  pending_events;
	int                  send_idle_pct = 0;
	int                  stall_pct = 0;
	int                  quiet_cycles = 0;

	kmmne_in_if  scan_bus();
	kmmne_out_if midi_bus();

	key_matrix_midi_note_events_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.scan    (scan_bus),
		.midi    (midi_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	note_event_checker note_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.scan           (scan_bus),
		.midi           (midi_bus),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.fail_count     (fail_count),
		.pending_events (pending_events)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		midi_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic apb_write(input reg_idx_t idx, input logic [ApbDataW-1:0] value);
		logic [ApbDataW-1:0] field_mask;
		field_mask = (idx == RegMidiChannel) ? 32'h0000_000F : 32'h0000_007F;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ApbAddrW'({idx, 2'b00});
		pwdata <= ($urandom() & ~field_mask) | (value & field_mask);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_voice(input int note, input int vel, input int chan);
		apb_write(RegBaseNote, note);
		apb_write(RegOnVelocity, vel);
		apb_write(RegMidiChannel, chan);
	endtask

	task automatic send_scan(input logic [1:0] column, input logic [3:0] levels, input logic link);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			scan_bus.valid <= 1'b0;
			scan_bus.column <= 2'($urandom_range(0, 3));
			scan_bus.row_levels <= 4'($urandom_range(0, 15));
			scan_bus.link_ready <= 1'($urandom_range(0, 1));
			@(posedge clk);
		end
		scan_bus.valid <= 1'b1;
		scan_bus.column <= column;
		scan_bus.row_levels <= levels;
		scan_bus.link_ready <= link;
		do @(posedge clk); while (!scan_bus.ready);
	endtask

	task automatic drain_events();
		scan_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending_events != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
	endtask

	initial begin
		while (quiet_cycles < WatchdogLimit) begin
			@(posedge clk);
			if ((scan_bus.valid && scan_bus.ready) || (midi_bus.valid && midi_bus.ready) || psel)
			begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("key_matrix_midi_note_events_unit test failed");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		scan_bus.valid <= 1'b0;
		scan_bus.column <= 2'd0;
		scan_bus.row_levels <= 4'hF;
		scan_bus.link_ready <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed scans under the reset voice settings.
		send_scan(2'd0, 4'h0, 1'b1);
		send_scan(2'd0, 4'hF, 1'b1);
		send_scan(2'd3, 4'h5, 1'b1);
		send_scan(2'd3, 4'h5, 1'b1);
		send_scan(2'd3, 4'hF, 1'b0);
		send_scan(2'd3, 4'hF, 1'b1);
		send_scan(2'd2, 4'h0, 1'b0);
		send_scan(2'd2, 4'hF, 1'b1);
		send_scan(2'd1, 4'hE, 1'b1);
		send_scan(2'd1, 4'hD, 1'b1);
		send_scan(2'd1, 4'hB, 1'b1);
		send_scan(2'd1, 4'h7, 1'b1);
		send_scan(2'd1, 4'hF, 1'b1);
		send_scan(2'd2, 4'hA, 1'b1);
		drain_events();

		// The highest base note makes the note numbers wrap around.
		set_voice(127, 127, 15);
		send_scan(2'd3, 4'h0, 1'b1);
		send_scan(2'd2, 4'h5, 1'b1);
		send_scan(2'd3, 4'hF, 1'b1);
		drain_events();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
					set_voice(0, 0, 0);
				end
				1: begin
					send_idle_pct = 78;
					stall_pct = 0;
					set_voice(112, 127, 15);
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 78;
					set_voice($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 15));
				end
				default: begin
					send_idle_pct = 20;
					stall_pct = 20;
					set_voice(127, $urandom_range(0, 127), $urandom_range(0, 15));
				end
			endcase
			repeat (ItemsPerPhase) begin
				send_scan(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
					$urandom_range(0, 99) < 85);
			end
			drain_events();
		end

		if (fail_count == 0) begin
			$display("key_matrix_midi_note_events_unit test passed");
		end else begin
			$display("key_matrix_midi_note_events_unit test failed");
		end
		$finish;
	end

endmodule

// File: key_matrix_midi_note_events_unit.f
rtl/core/kmmne_pkg.sv
rtl/core/kmmne_if.sv
rtl/core/kmmne_fifo.sv
rtl/core/kmmne_front.sv
rtl/core/kmmne_back.sv
rtl/core/key_matrix_midi_note_events_unit.sv
sim/note_event_checker.sv
sim/tb_key_matrix_midi_note_events_unit.sv
